/* rtl/core/tsq_pkg.sv */
// Triangle shape quality: shared widths, item types and pipeline latency.
// No dependencies; imported by every module of the block.
package tsq_pkg;

  localparam int CW   = 24;              // coordinate width
  localparam int QF   = 16;              // quality fraction bits
  localparam int DW   = CW + 1;          // edge vector component width
  localparam int DENW = 2 * CW + 4;      // sum of squared edge lengths
  localparam int NW   = 2 * CW + 2;      // cross product component
  localparam int HL   = NW / 2;          // half of |n| for split squaring
  localparam int NSQW = 4 * CW + 6;      // 3 * |n|^2
  localparam int RW   = NSQW + 2 * QF + 2; // radicand
  localparam int SW   = RW / 2;          // integer root
  localparam int QW   = QF + 1;          // quality width
  localparam int RMW  = DENW + QF + 1;   // divider remainder
  localparam int LAT  = SW + QW + 8;     // accept edge to result edge

  typedef struct packed {
    logic signed [CW-1:0] first_x;
    logic signed [CW-1:0] first_y;
    logic signed [CW-1:0] first_z;
    logic signed [CW-1:0] second_x;
    logic signed [CW-1:0] second_y;
    logic signed [CW-1:0] second_z;
    logic signed [CW-1:0] third_x;
    logic signed [CW-1:0] third_y;
    logic signed [CW-1:0] third_z;
  } tsq_in_t;

  typedef struct packed {
    logic [QW-1:0] quality;
    logic          degenerate;
  } tsq_out_t;

endpackage

/* rtl/core/tsq_front.sv */
// Front pipeline: edge vectors, squared lengths, cross product, radicand.
// Depends on tsq_pkg. Six register stages, one item per cycle.
module tsq_front
  import tsq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  tsq_in_t          in_item,
  output logic             out_valid,
  output logic [RW-1:0]    out_rad,
  output logic [DENW-1:0]  out_den,
  output logic             out_deg
);

  logic signed [CW-1:0]   c[9];
  logic signed [DW-1:0]   d_nxt[9], d_r[9];
  logic [2*CW:0]          sq_nxt[9], sq_r[9];
  logic signed [2*DW-1:0] cp_nxt[6], cp_r[6];
  logic [DENW-1:0]        den_nxt, den3_r, den4_r, den5_r, den6_r;
  logic [NW-1:0]          an_nxt[3], an_r[3];
  logic [2*HL-1:0]        hh_r[3], hl_r[3], ll_r[3];
  logic [4*HL-1:0]        nk_nxt[3], nk_r[3];
  logic [RW-1:0]          rad_nxt, rad_r;
  logic                   deg4_r, deg5_r, deg6_r;
  logic [5:0]             v_r;

  assign c[0] = in_item.first_x;
  assign c[1] = in_item.first_y;
  assign c[2] = in_item.first_z;
  assign c[3] = in_item.second_x;
  assign c[4] = in_item.second_y;
  assign c[5] = in_item.second_z;
  assign c[6] = in_item.third_x;
  assign c[7] = in_item.third_y;
  assign c[8] = in_item.third_z;

  // d12, d13, d23
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_nxt[i]   = $signed({c[3+i][CW-1], c[3+i]}) - $signed({c[i][CW-1], c[i]});
      d_nxt[3+i] = $signed({c[6+i][CW-1], c[6+i]}) - $signed({c[i][CW-1], c[i]});
      d_nxt[6+i] = $signed({c[6+i][CW-1], c[6+i]}) - $signed({c[3+i][CW-1], c[3+i]});
    end
  end

  always_comb begin
    logic signed [2*DW-1:0] p;
    for (int i = 0; i < 9; i++) begin
      p         = d_r[i] * d_r[i];
      sq_nxt[i] = p[2*CW:0];
    end
    cp_nxt[0] = d_r[1] * d_r[5];
    cp_nxt[1] = d_r[2] * d_r[4];
    cp_nxt[2] = d_r[2] * d_r[3];
    cp_nxt[3] = d_r[0] * d_r[5];
    cp_nxt[4] = d_r[0] * d_r[4];
    cp_nxt[5] = d_r[1] * d_r[3];
  end

  always_comb begin
    logic [DENW-1:0]      acc;
    logic signed [2*DW:0] df;
    logic [2*DW:0]        mag;
    acc = '0;
    for (int i = 0; i < 9; i++) begin
      acc = acc + DENW'(sq_r[i]);
    end
    den_nxt = acc;
    for (int k = 0; k < 3; k++) begin
      df = $signed({cp_r[2*k][2*DW-1], cp_r[2*k]})
         - $signed({cp_r[2*k+1][2*DW-1], cp_r[2*k+1]});
      mag       = df[2*DW] ? (2*DW+1)'(-df) : (2*DW+1)'(df);
      an_nxt[k] = mag[NW-1:0];
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nk_nxt[k] = ((4*HL)'(hh_r[k]) << (2*HL)) + ((4*HL)'(hl_r[k]) << (HL+1))
                + (4*HL)'(ll_r[k]);
    end
  end

  always_comb begin
    logic [4*HL-1:0] s;
    logic [NSQW-1:0] t;
    s       = nk_r[0] + nk_r[1] + nk_r[2];
    t       = NSQW'({s, 1'b0}) + NSQW'(s);
    rad_nxt = {t, (2*QF+2)'(0)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    d_r    <= d_nxt;
    sq_r   <= sq_nxt;
    cp_r   <= cp_nxt;
    den3_r <= den_nxt;
    an_r   <= an_nxt;
    for (int k = 0; k < 3; k++) begin
      hh_r[k] <= an_r[k][NW-1:HL] * an_r[k][NW-1:HL];
      hl_r[k] <= an_r[k][NW-1:HL] * an_r[k][HL-1:0];
      ll_r[k] <= an_r[k][HL-1:0] * an_r[k][HL-1:0];
    end
    den4_r <= den3_r;
    deg4_r <= (den3_r == '0);
    nk_r   <= nk_nxt;
    den5_r <= den4_r;
    deg5_r <= deg4_r;
    rad_r  <= rad_nxt;
    den6_r <= den5_r;
    deg6_r <= deg5_r;
  end

  assign out_valid = v_r[5];
  assign out_rad   = rad_r;
  assign out_den   = den6_r;
  assign out_deg   = deg6_r;

endmodule

/* rtl/core/tsq_sqrt_cell.sv */
// One cell of the integer square root chain: settles one root bit.
// Depends on tsq_pkg for default widths; the top level hands them down.
module tsq_sqrt_cell
  import tsq_pkg::*;
#(
  parameter int RADW = RW,
  parameter int ROOTW = SW,
  parameter int DENW_P = DENW
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [RADW-1:0]   in_rad,
  input  logic [ROOTW+1:0]  in_rem,
  input  logic [ROOTW-1:0]  in_root,
  input  logic [DENW_P-1:0] in_den,
  input  logic              in_deg,
  output logic              out_valid,
  output logic [RADW-1:0]   out_rad,
  output logic [ROOTW+1:0]  out_rem,
  output logic [ROOTW-1:0]  out_root,
  output logic [DENW_P-1:0] out_den,
  output logic              out_deg
);

  logic [ROOTW+1:0] rem_sh, trial, rem_nxt;
  logic             ge;
  logic             valid_r;

  assign rem_sh  = {in_rem[ROOTW-1:0], in_rad[RADW-1:RADW-2]};
  assign trial   = {in_root, 2'b01};
  assign ge      = (rem_sh >= trial);
  assign rem_nxt = ge ? rem_sh - trial : rem_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_rad  <= {in_rad[RADW-3:0], 2'b00};
    out_rem  <= rem_nxt;
    out_root <= {in_root[ROOTW-2:0], ge};
    out_den  <= in_den;
    out_deg  <= in_deg;
  end

  assign out_valid = valid_r;

endmodule

/* rtl/core/tsq_div_cell.sv */
// One cell of the restoring divider chain: settles one quotient bit.
// Depends on tsq_pkg for default widths; the top level hands them down.
module tsq_div_cell
  import tsq_pkg::*;
#(
  parameter int DENW_P = DENW,
  parameter int FB = QF,
  parameter int QW_P = QW,
  parameter int REMW = RMW
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [REMW-1:0]   in_rem,
  input  logic [QW_P-1:0]   in_q,
  input  logic [DENW_P-1:0] in_den,
  input  logic              in_deg,
  input  logic              in_ovf,
  output logic              out_valid,
  output logic [REMW-1:0]   out_rem,
  output logic [QW_P-1:0]   out_q,
  output logic [DENW_P-1:0] out_den,
  output logic              out_deg,
  output logic              out_ovf
);

  logic [REMW-1:0] dv, rem_t;
  logic            ge;
  logic            valid_r;

  assign dv    = REMW'({in_den, FB'(0)});
  assign ge    = (in_rem >= dv);
  assign rem_t = ge ? in_rem - dv : in_rem;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_rem <= {rem_t[REMW-2:0], 1'b0};
    out_q   <= {in_q[QW_P-2:0], ge};
    out_den <= in_den;
    out_deg <= in_deg;
    out_ovf <= in_ovf;
  end

  assign out_valid = valid_r;

endmodule

/* rtl/core/triangle_shape_quality_3d.sv */
// Triangle shape quality 4*sqrt(3)*area / sum of squared edges, Q1.16.
// Depends on tsq_pkg, tsq_front, tsq_sqrt_cell, tsq_div_cell.
//
//  channel  ports                         direction  handshake
//  input    start, busy, in_item          in         start && !busy
//  result   out_valid, out_item           out        one-cycle strobe
//
// Cycles: one item per cycle; busy is always low.
// Pipeline: the root chain (one cell per root bit) and the divider chain
// (one cell per quality bit, Q1.16) behind a six-stage front end.
// Reset: synchronous, active low; clears all item valid flags.
// Stalls: none, the receiver takes each result in its strobe cycle.
//
// Math: k = floor(isqrt(3*|n|^2 * 2^(2F+2)) / den), clamped to 2^F, which
// equals the largest k with k^2*den^2 <= 3*|n|^2*2^(2F+2).
module triangle_shape_quality_3d
  import tsq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  tsq_in_t  in_item,
  output logic     out_valid,
  output tsq_out_t out_item
);

  // front end
  logic            f_valid;
  logic [RW-1:0]   f_rad;
  logic [DENW-1:0] f_den;
  logic            f_deg;

  assign busy = 1'b0;

  tsq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start),
    .in_item   (in_item),
    .out_valid (f_valid),
    .out_rad   (f_rad),
    .out_den   (f_den),
    .out_deg   (f_deg)
  );

  // square root chain: tap k feeds cell k
  logic            s_valid[SW+1];
  logic [RW-1:0]   s_rad[SW+1];
  logic [SW+1:0]   s_rem[SW+1];
  logic [SW-1:0]   s_root[SW+1];
  logic [DENW-1:0] s_den[SW+1];
  logic            s_deg[SW+1];

  assign s_valid[0] = f_valid;
  assign s_rad[0]   = f_rad;
  assign s_rem[0]   = '0;
  assign s_root[0]  = '0;
  assign s_den[0]   = f_den;
  assign s_deg[0]   = f_deg;

  for (genvar k = 0; k < SW; k++) begin : g_sqrt
    tsq_sqrt_cell #(
      .RADW   (RW),
      .ROOTW  (SW),
      .DENW_P (DENW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (s_valid[k]),
      .in_rad    (s_rad[k]),
      .in_rem    (s_rem[k]),
      .in_root   (s_root[k]),
      .in_den    (s_den[k]),
      .in_deg    (s_deg[k]),
      .out_valid (s_valid[k+1]),
      .out_rad   (s_rad[k+1]),
      .out_rem   (s_rem[k+1]),
      .out_root  (s_root[k+1]),
      .out_den   (s_den[k+1]),
      .out_deg   (s_deg[k+1])
    );
  end

  // divider entry: flag a quotient of 2^(F+1) or more before the chain
  logic            e_valid_r;
  logic [RMW-1:0]  e_rem_r;
  logic [DENW-1:0] e_den_r;
  logic            e_deg_r;
  logic            e_ovf_r;
  logic [RMW-1:0]  root_ext;

  assign root_ext = RMW'(s_root[SW]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
    end else begin
      e_valid_r <= s_valid[SW];
    end
  end

  always_ff @(posedge clk) begin
    e_rem_r <= root_ext;
    e_den_r <= s_den[SW];
    e_deg_r <= s_deg[SW];
    e_ovf_r <= (root_ext >= {s_den[SW], (QF+1)'(0)});
  end

  // divider chain
  logic            q_valid[QW+1];
  logic [RMW-1:0]  q_rem[QW+1];
  logic [QW-1:0]   q_q[QW+1];
  logic [DENW-1:0] q_den[QW+1];
  logic            q_deg[QW+1];
  logic            q_ovf[QW+1];

  assign q_valid[0] = e_valid_r;
  assign q_rem[0]   = e_rem_r;
  assign q_q[0]     = '0;
  assign q_den[0]   = e_den_r;
  assign q_deg[0]   = e_deg_r;
  assign q_ovf[0]   = e_ovf_r;

  for (genvar k = 0; k < QW; k++) begin : g_div
    tsq_div_cell #(
      .DENW_P (DENW),
      .FB     (QF),
      .QW_P   (QW),
      .REMW   (RMW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (q_valid[k]),
      .in_rem    (q_rem[k]),
      .in_q      (q_q[k]),
      .in_den    (q_den[k]),
      .in_deg    (q_deg[k]),
      .in_ovf    (q_ovf[k]),
      .out_valid (q_valid[k+1]),
      .out_rem   (q_rem[k+1]),
      .out_q     (q_q[k+1]),
      .out_den   (q_den[k+1]),
      .out_deg   (q_deg[k+1]),
      .out_ovf   (q_ovf[k+1])
    );
  end

  // output register: degenerate forces zero, otherwise clamp to 1.0
  localparam logic [QW-1:0] ONE = QW'(1) << QF;

  logic     out_valid_r;
  tsq_out_t out_item_nxt, out_item_r;

  always_comb begin
    out_item_nxt.degenerate = q_deg[QW];
    if (q_deg[QW]) begin
      out_item_nxt.quality = '0;
    end else if (q_ovf[QW] || (q_q[QW] > ONE)) begin
      out_item_nxt.quality = ONE;
    end else begin
      out_item_nxt.quality = q_q[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= q_valid[QW];
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* rtl/core/tsq_checker.sv */
// Port-level checks for the triangle quality block, bound to the top level.
// Depends on tsq_pkg.
module tsq_checker
  import tsq_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_valid,
  input tsq_out_t out_item
);

  localparam logic [QW-1:0] ONE = QW'(1) << QF;

  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && rst_n, LAT))
    else $error("result without a matching item");

  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.degenerate |-> out_item.quality == '0)
    else $error("degenerate item with nonzero quality");

  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.quality <= ONE)
    else $error("quality above 1.0");

endmodule

bind triangle_shape_quality_3d tsq_checker u_tsq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);
